@@ rtl/sclm_pkg.sv @@
// shared types, constants and command word table for the serial command line matcher
package sclm_pkg;

   localparam int LINE_STORE_BYTES_DEFAULT = 16;
   localparam int WORD_COUNT = 7;
   localparam int WORD_LEN_BITS = 3;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   localparam logic [2:0] CMD_START = 3'd0;
   localparam logic [2:0] CMD_D = 3'd1;
   localparam logic [2:0] CMD_A = 3'd2;
   localparam logic [2:0] CMD_W = 3'd3;
   localparam logic [2:0] CMD_S = 3'd4;
   localparam logic [2:0] CMD_J = 3'd5;
   localparam logic [2:0] CMD_STOP = 3'd6;
   localparam logic [2:0] CMD_NONE = 3'd7;

   typedef struct packed {
      logic       recognized;
      logic [2:0] command_index;
      logic [3:0] line_length;
   } sclm_result_type;

   // word text, first character in the low byte, unused bytes zero
   function automatic logic [63:0] word_text(input logic [2:0] cmd);
      logic [63:0] text;
      case (cmd)
         CMD_START: text = {24'h000000, "trats"};
         CMD_D:     text = {56'h0, "d"};
         CMD_A:     text = {56'h0, "a"};
         CMD_W:     text = {56'h0, "w"};
         CMD_S:     text = {56'h0, "s"};
         CMD_J:     text = {56'h0, "j"};
         CMD_STOP:  text = {32'h00000000, "pots"};
         default:   text = 64'h0;
      endcase
      return text;
   endfunction

   function automatic logic [WORD_LEN_BITS-1:0] word_len(input logic [2:0] cmd);
      logic [WORD_LEN_BITS-1:0] len;
      case (cmd)
         CMD_START: len = 3'd5;
         CMD_D, CMD_A, CMD_W, CMD_S, CMD_J: len = 3'd1;
         CMD_STOP:  len = 3'd4;
         default:   len = 3'd0;
      endcase
      return len;
   endfunction

endpackage

@@ rtl/sclm_tracker.sv @@
// line tracker: per-character prefix match against each command word
module sclm_tracker #(
   parameter int LINE_STORE_BYTES = sclm_pkg::LINE_STORE_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      byte_valid,
   input  logic [7:0]                byte_data,
   input  logic                      advance,
   output logic                      emit,
   output sclm_pkg::sclm_result_type result
);

   localparam int CW = $clog2(LINE_STORE_BYTES);
   localparam logic [CW-1:0] LINE_CAP = CW'(LINE_STORE_BYTES - 1);
   localparam int WC = sclm_pkg::WORD_COUNT;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] len_ff, len_in;
   logic          zero_seen_ff, zero_seen_in;
   logic [WC-1:0] ok_ff, ok_in;

   logic          is_term;
   logic [WC-1:0] char_hit;
   logic [WC-1:0] word_match;
   logic [CW+3:0] len_ext;
   logic [63:0]   word_bits;

   assign is_term = (byte_data == sclm_pkg::CHAR_CR) || (byte_data == sclm_pkg::CHAR_LF);
   assign emit = byte_valid && is_term && (count_ff != '0);
   assign len_ext = {4'b0000, len_ff};

   always_comb begin
      word_bits = '0;
      for (int w = 0; w < WC; w++) begin
         word_bits = sclm_pkg::word_text(3'(w));
         // line position len_ff must lie inside the word and carry the same character
         char_hit[w] = (len_ff < CW'(sclm_pkg::word_len(3'(w)))) &&
            (byte_data == word_bits[len_ff[2:0]*8 +: 8]);
         word_match[w] = ok_ff[w] && (len_ff == CW'(sclm_pkg::word_len(3'(w))));
      end
   end

   always_comb begin
      result.recognized = |word_match;
      result.command_index = sclm_pkg::CMD_NONE;
      for (int w = WC - 1; w >= 0; w--) begin
         if (word_match[w]) begin
            result.command_index = 3'(w);
         end
      end
      result.line_length = len_ext[3:0];
   end

   always_comb begin
      count_in = count_ff;
      len_in = len_ff;
      zero_seen_in = zero_seen_ff;
      ok_in = ok_ff;
      if (advance) begin
         if (is_term) begin
            if (count_ff != '0) begin
               count_in = '0;
               len_in = '0;
               zero_seen_in = 1'b0;
               ok_in = '1;
            end
         end else if (count_ff < LINE_CAP) begin
            count_in = count_ff + 1'b1;
            if (!zero_seen_ff) begin
               // matching and length stop at the first zero byte
               if (byte_data == sclm_pkg::CHAR_NUL) begin
                  zero_seen_in = 1'b1;
               end else begin
                  len_in = len_ff + 1'b1;
                  ok_in = ok_ff & char_hit;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         len_ff <= '0;
         zero_seen_ff <= 1'b0;
         ok_ff <= '1;
      end else begin
         count_ff <= count_in;
         len_ff <= len_in;
         zero_seen_ff <= zero_seen_in;
         ok_ff <= ok_in;
      end
   end

endmodule

@@ rtl/serial_command_line_matcher.sv @@
// Serial command line matcher: collects received bytes into a line of up to
// LINE_STORE_BYTES-1 characters (extra characters are dropped) and, on CR or LF
// after a non-empty line, reports whether the line up to its first zero byte
// equals one of the words start, d, a, w, s, j, stop, which one, and the length
// up to the first zero byte; a terminator on an empty line gives no response.
// One request is taken every cycle while the line does not stall: a byte passes
// an input register, updates per-word match flags, and a response lands in an
// output register. A terminator's response enters the output register once
// the terminator has left the input register and the output register is free;
// the line only stalls when an untaken response sits there and a new one is due.
module serial_command_line_matcher #(
   parameter int LINE_STORE_BYTES = sclm_pkg::LINE_STORE_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_recognized,
   output logic [2:0] rsp_command_index,
   output logic [3:0] rsp_line_length
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   sclm_pkg::sclm_result_type out_ff, out_in;

   logic emit;
   logic advance;
   logic out_free;
   sclm_pkg::sclm_result_type result;

   sclm_tracker #(
      .LINE_STORE_BYTES(LINE_STORE_BYTES)
   ) u_tracker (
      .clock     (clock),
      .reset     (reset),
      .byte_valid(in_valid_ff),
      .byte_data (in_byte_ff),
      .advance   (advance),
      .emit      (emit),
      .result    (result)
   );

   assign out_free = !out_valid_ff || rsp_ready;
   assign advance = in_valid_ff && (!emit || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in = in_byte_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
         in_byte_in = req_rx_byte;
      end
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in = out_ff;
      if (advance && emit) begin
         out_valid_in = 1'b1;
         out_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff <= in_byte_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_recognized = out_ff.recognized;
   assign rsp_command_index = out_ff.command_index;
   assign rsp_line_length = out_ff.line_length;

endmodule
